// File: src/chd_pkg.sv
package chd_pkg;

	// Characters that steer the header and size-line parsing.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_T  = 8'h54;

	// The header line that is removed, "Transfer-Encoding: chunked" CR LF.
	localparam int unsigned PAT_LEN = 28;
	localparam logic [4:0] PAT_LAST = 5'(PAT_LEN - 1);

	// Command queue between the parser and the result expander.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PASS,
		PH_SIZE,
		PH_DATA,
		PH_TRAIL,
		PH_DROP
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_end;
		logic       stream_end;
		logic       size_error;
	} out_item_t;

	// One command describes every word that one input byte causes: a number
	// of held pattern bytes, then optionally the byte itself, then optionally
	// a marker word.
	typedef struct packed {
		logic [4:0] flush;
		logic       has_byte;
		logic [7:0] data;
		logic       mark;
		logic       err;
		logic       last;
		logic [4:0] total_m1;
	} cmd_t;

	// Byte i of the removed header line.
	function automatic logic [7:0] pat_byte(input logic [4:0] i);
		logic [7:0] r;
		unique case (i)
			5'd0:    r = "T";
			5'd1:    r = "r";
			5'd2:    r = "a";
			5'd3:    r = "n";
			5'd4:    r = "s";
			5'd5:    r = "f";
			5'd6:    r = "e";
			5'd7:    r = "r";
			5'd8:    r = "-";
			5'd9:    r = "E";
			5'd10:   r = "n";
			5'd11:   r = "c";
			5'd12:   r = "o";
			5'd13:   r = "d";
			5'd14:   r = "i";
			5'd15:   r = "n";
			5'd16:   r = "g";
			5'd17:   r = ":";
			5'd18:   r = " ";
			5'd19:   r = "c";
			5'd20:   r = "h";
			5'd21:   r = "u";
			5'd22:   r = "n";
			5'd23:   r = "k";
			5'd24:   r = "e";
			5'd25:   r = "d";
			5'd26:   r = CH_CR;
			5'd27:   r = CH_LF;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Hex digit decode: bit 4 says the byte is a digit, bits 3..0 its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		if (b >= "0" && b <= "9") begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= "a" && b <= "f") begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= "A" && b <= "F") begin
			r = {1'b1, 4'(b - 8'h37)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

// File: src/chd_stream_if.sv
interface chd_stream_if #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/chd_front.sv
module chd_front #(
	parameter int unsigned SIZE_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	chd_stream_if.sink    raw,
	output chd_pkg::cmd_t cmd,
	output logic          cmd_push,
	input  logic          q_full
);

	chd_pkg::phase_t        phase_q, phase_n;
	logic [1:0]             hep_q, hep_n, hep_next;
	logic [4:0]             idx_q, idx_n;
	logic                   removed_q, removed_n;
	logic [SIZE_BITS-1:0]   chunk_q, chunk_n, chunk_dec;
	logic                   dseen_q, dseen_n;
	logic                   dstop_q, dstop_n;
	logic                   pcr_q, pcr_n;
	logic [1:0]             skip_q, skip_n, skip_dec;

	logic [7:0] b;
	logic       last;
	logic       accept;
	logic       pat_hit;
	logic       hdr_done;
	logic [4:0] hex;
	logic       sat;
	logic       line_end;

	assign b        = raw.data.in_byte;
	assign last     = raw.data.in_last;
	assign raw.ready = !q_full;
	assign accept   = raw.valid && !q_full;

	// Shared decodes of the current byte.
	assign pat_hit   = (b == chd_pkg::pat_byte(idx_q));
	assign hdr_done  = (hep_q == 2'd3) && (b == chd_pkg::CH_LF);
	assign hex       = chd_pkg::hex_decode(b);
	assign sat       = (chunk_q[SIZE_BITS-1 -: 4] != 4'd0);
	assign line_end  = pcr_q && (b == chd_pkg::CH_LF);
	assign chunk_dec = (chunk_q != '0) ? chunk_q - SIZE_BITS'(1) : chunk_q;
	assign skip_dec  = (skip_q != 2'd0) ? skip_q - 2'd1 : skip_q;

	// Progress towards the blank line that ends the header.
	always_comb begin
		unique case (hep_q)
			2'd0: hep_next = (b == chd_pkg::CH_CR) ? 2'd1 : 2'd0;
			2'd1: hep_next = (b == chd_pkg::CH_LF) ? 2'd2 :
				(b == chd_pkg::CH_CR) ? 2'd1 : 2'd0;
			2'd2: hep_next = (b == chd_pkg::CH_CR) ? 2'd3 : 2'd0;
			default: hep_next = (b == chd_pkg::CH_CR) ? 2'd1 : 2'd0;
		endcase
	end

	// Next state of the parser.
	always_comb begin
		phase_n   = phase_q;
		hep_n     = hep_q;
		idx_n     = idx_q;
		removed_n = removed_q;
		chunk_n   = chunk_q;
		dseen_n   = dseen_q;
		dstop_n   = dstop_q;
		pcr_n     = pcr_q;
		skip_n    = skip_q;
		unique case (phase_q)
			chd_pkg::PH_HEADER: begin
				if (!removed_q) begin
					if (pat_hit) begin
						if (idx_q == chd_pkg::PAT_LAST) begin
							removed_n = 1'b1;
							idx_n     = 5'd0;
						end else begin
							idx_n = idx_q + 5'd1;
						end
					end else if (b == chd_pkg::CH_T) begin
						idx_n = 5'd1;
					end else begin
						idx_n = 5'd0;
					end
				end
				hep_n = hep_next;
				if (hdr_done) begin
					hep_n   = 2'd0;
					phase_n = removed_n ? chd_pkg::PH_SIZE : chd_pkg::PH_PASS;
					chunk_n = '0;
					dseen_n = 1'b0;
					dstop_n = 1'b0;
					pcr_n   = 1'b0;
				end
			end
			chd_pkg::PH_SIZE: begin
				if (line_end) begin
					if (!dseen_q || chunk_q == '0) begin
						phase_n = chd_pkg::PH_DROP;
					end else begin
						phase_n = chd_pkg::PH_DATA;
					end
					pcr_n = 1'b0;
				end else begin
					if (hex[4] && !dstop_q) begin
						chunk_n = sat ? '1 : {chunk_q[SIZE_BITS-5:0], hex[3:0]};
						dseen_n = 1'b1;
					end else if (!(b == chd_pkg::CH_SP && !dseen_q)) begin
						dstop_n = 1'b1;
					end
					pcr_n = (b == chd_pkg::CH_CR);
				end
			end
			chd_pkg::PH_DATA: begin
				chunk_n = chunk_dec;
				if (chunk_dec == '0) begin
					phase_n = chd_pkg::PH_TRAIL;
					skip_n  = 2'd2;
				end
			end
			chd_pkg::PH_TRAIL: begin
				skip_n = skip_dec;
				if (skip_dec == 2'd0) begin
					phase_n = chd_pkg::PH_SIZE;
					chunk_n = '0;
					dseen_n = 1'b0;
					dstop_n = 1'b0;
					pcr_n   = 1'b0;
				end
			end
			default: begin
				// Pass-through and drop phases keep their state.
			end
		endcase
		// The final byte of a request returns everything to its reset state.
		if (last) begin
			phase_n   = chd_pkg::PH_HEADER;
			hep_n     = 2'd0;
			idx_n     = 5'd0;
			removed_n = 1'b0;
			chunk_n   = '0;
			dseen_n   = 1'b0;
			dstop_n   = 1'b0;
			pcr_n     = 1'b0;
			skip_n    = 2'd0;
		end
	end

	// Command for the result expander.
	always_comb begin
		cmd          = '0;
		cmd.data     = b;
		cmd.last     = last;
		unique case (phase_q)
			chd_pkg::PH_HEADER: begin
				if (removed_q) begin
					cmd.has_byte = 1'b1;
				end else if (!pat_hit) begin
					// Held prefix goes out again; a 'T' starts a new match
					// unless the request ends here.
					cmd.flush    = idx_q;
					cmd.has_byte = (b != chd_pkg::CH_T) || last;
				end else if (last && idx_q != chd_pkg::PAT_LAST) begin
					cmd.flush = idx_q + 5'd1;
				end
			end
			chd_pkg::PH_PASS, chd_pkg::PH_DATA: begin
				cmd.has_byte = 1'b1;
			end
			chd_pkg::PH_SIZE: begin
				cmd.err = line_end && !dseen_q;
			end
			default: begin
			end
		endcase
		cmd.mark     = cmd.err || (last && cmd.flush == 5'd0 && !cmd.has_byte);
		cmd.total_m1 = cmd.flush + {4'd0, cmd.has_byte} + {4'd0, cmd.mark} - 5'd1;
		cmd_push     = accept && (cmd.flush != 5'd0 || cmd.has_byte || cmd.mark);
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= chd_pkg::PH_HEADER;
			hep_q     <= 2'd0;
			idx_q     <= 5'd0;
			removed_q <= 1'b0;
			chunk_q   <= '0;
			dseen_q   <= 1'b0;
			dstop_q   <= 1'b0;
			pcr_q     <= 1'b0;
			skip_q    <= 2'd0;
		end else if (accept) begin
			phase_q   <= phase_n;
			hep_q     <= hep_n;
			idx_q     <= idx_n;
			removed_q <= removed_n;
			chunk_q   <= chunk_n;
			dseen_q   <= dseen_n;
			dstop_q   <= dstop_n;
			pcr_q     <= pcr_n;
			skip_q    <= skip_n;
		end
	end

endmodule

// File: src/chd_queue.sv
module chd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  chd_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output chd_pkg::cmd_t head,
	output logic          head_valid
);

	chd_pkg::cmd_t                 entry_q [chd_pkg::Q_DEPTH];
	logic [chd_pkg::Q_AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [chd_pkg::Q_CW-1:0]      count_q;

	assign full       = (count_q == chd_pkg::Q_CW'(chd_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + chd_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + chd_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + chd_pkg::Q_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - chd_pkg::Q_CW'(1);
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: src/chd_back.sv
module chd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  chd_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          pop,
	chd_stream_if.source  clean
);

	logic [4:0]         pos_q;
	logic               ov_q;
	chd_pkg::out_item_t word_q;
	chd_pkg::out_item_t word;
	logic               emit;
	logic               final_word;

	assign emit       = head_valid && (!ov_q || clean.ready);
	assign final_word = (pos_q == head.total_m1);
	assign pop        = emit && final_word;

	assign clean.valid = ov_q;
	assign clean.data  = word_q;

	// Word at the current position of the head command.
	always_comb begin
		word = '0;
		if (pos_q < head.flush) begin
			word.out_byte   = chd_pkg::pat_byte(pos_q);
			word.byte_valid = 1'b1;
		end else if (pos_q == head.flush && head.has_byte) begin
			word.out_byte   = head.data;
			word.byte_valid = 1'b1;
		end else begin
			word.size_error = head.err;
		end
		word.run_end    = final_word;
		word.stream_end = final_word && head.last;
	end

	// Position within the command and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
			ov_q  <= 1'b0;
		end else begin
			if (emit) begin
				pos_q <= final_word ? 5'd0 : pos_q + 5'd1;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (clean.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= word;
		end
	end

endmodule

// File: src/http_chunked_body_decoder.sv
// Each output word passes through the command queue and then the output word register.
// Throughput: one input byte and one output word per cycle while the queue has room and clean is ready;
// a byte that releases a held partial header match occupies the result expander for one cycle
// per word it causes (up to 28). The four-entry command queue lets the parser run on meanwhile.
// Reset (arst_n low, asynchronous) clears the parser, the queue and the output valid flag.
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	chd_stream_if.sink   raw,
	chd_stream_if.source clean
);

	chd_pkg::cmd_t cmd;
	chd_pkg::cmd_t head;
	logic          cmd_push;
	logic          q_full;
	logic          head_valid;
	logic          pop;

	chd_front #(
		.SIZE_BITS(SIZE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.cmd      (cmd),
		.cmd_push (cmd_push),
		.q_full   (q_full)
	);

	chd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.wdata      (cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	chd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.clean      (clean)
	);

endmodule

// File: src/chd_checker.sv
module chd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_byte,
	input logic       tx_byte_valid,
	input logic       tx_run_end,
	input logic       tx_stream_end,
	input logic       tx_size_error
);

	// A stalled word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid)
		else $error("output word withdrawn while stalled");

	// A stalled word keeps its contents.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> $stable(tx_byte) && $stable(tx_byte_valid)
			&& $stable(tx_run_end) && $stable(tx_stream_end) && $stable(tx_size_error))
		else $error("output word changed while stalled");

	// The end of a request is always the end of its byte's run.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_stream_end |-> tx_run_end)
		else $error("stream end without run end");

	// A size error is a lone marker word.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_size_error |-> !tx_byte_valid && tx_run_end)
		else $error("size error on a data word or mid-run");

	// Marker words carry a zero byte and close their run.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_byte_valid |-> tx_byte == 8'h00 && tx_run_end)
		else $error("malformed marker word");

endmodule

bind http_chunked_body_decoder chd_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (clean.valid),
	.tx_ready      (clean.ready),
	.tx_byte       (clean.data.out_byte),
	.tx_byte_valid (clean.data.byte_valid),
	.tx_run_end    (clean.data.run_end),
	.tx_stream_end (clean.data.stream_end),
	.tx_size_error (clean.data.size_error)
);
